>>> src/vertex_weld_dedup_defines.svh
// Assertion macros used by the checker file.
`ifndef VERTEX_WELD_DEDUP_DEFINES_SVH
`define VERTEX_WELD_DEDUP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define VWD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define VWD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> src/vwd_pkg.sv
// Package: widths, register codes and the result, config and vertex types of the vertex weld block.
`timescale 1ns / 1ps
package vwd_pkg;
  localparam int MaxVerts = 1024;
  localparam int IdxW = $clog2(MaxVerts);
  localparam int CntW = IdxW + 1;
  localparam int OutIdxW = 10;
  localparam int EntryW = 32 * 5 + 48;
  localparam int AddrW = 4;

  localparam logic [AddrW-1:0] RegPosTol = 4'h0;
  localparam logic [AddrW-1:0] RegTexTol = 4'h4;
  localparam logic [AddrW-1:0] RegCosThr = 4'h8;

  typedef struct packed {
    logic [OutIdxW-1:0] vertex_index;
    logic               is_new;
    logic               table_full;
  } result_t;

  typedef struct packed {
    logic [15:0] pos_tol;
    logic [15:0] tex_tol;
    logic [14:0] cos_thr;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_s;
    logic signed [31:0] tex_t;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } vtx_t;
endpackage

>>> src/vwd_if.sv
// Valid/ready channel interfaces for vertex requests and index results.
`timescale 1ns / 1ps
interface vwd_in_if;
  logic               valid;
  logic               ready;
  logic               first_of_surface;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] tex_s;
  logic signed [31:0] tex_t;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [31:0]        color_rgba;
  modport source (output valid, first_of_surface, pos_x, pos_y, pos_z, tex_s, tex_t,
                  normal_x, normal_y, normal_z, color_rgba, input ready);
  modport sink (input valid, first_of_surface, pos_x, pos_y, pos_z, tex_s, tex_t,
                normal_x, normal_y, normal_z, color_rgba, output ready);
endinterface

interface vwd_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] vertex_index;
  logic       is_new;
  logic       table_full;
  modport source (output valid, vertex_index, is_new, table_full, input ready);
  modport sink (input valid, vertex_index, is_new, table_full, output ready);
endinterface

>>> src/vertex_weld_dedup.sv
// Throughput: one request at a time; the scan reads one table entry per cycle
// through a single RAM read port into a two-stage compare unit.
// A result waits in an output register; the next request is taken once it drains.
// Reset (synchronous, rst_n low) empties the table count and loads default tolerances.
// No clearing pass: entries at or above the count never give a match result.
`timescale 1ns / 1ps
module vertex_weld_dedup (
  input  logic        clk,
  input  logic        rst_n,
  vwd_in_if.sink      in_ch,
  vwd_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDone = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  localparam int IdxW = vwd_pkg::IdxW;
  localparam int CntW = vwd_pkg::CntW;

  logic [2:0]          state_r, state_nxt;
  vwd_pkg::cfg_t       cfg_r;
  vwd_pkg::vtx_t       cur_r;
  logic [31:0]         color_r;
  logic [CntW-1:0]     count_r, count_nxt;
  logic [CntW-1:0]     rd_r, rd_nxt;       // next address issued
  logic [CntW-1:0]     chk_r;              // index whose compare result is at hit
  logic [1:0]          vld_r;              // read data, compare result in flight
  logic [CntW-1:0]     k1_r, k2_r;
  vwd_pkg::result_t    res_r, res_nxt;
  vwd_pkg::vtx_t       ent;
  logic                hit;
  logic                we;
  logic                in_acc;
  logic                cfg_wr;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_ch.ready = (state_r == StIdle);
  assign out_ch.valid = (state_r == StOut);
  assign out_ch.vertex_index = res_r.vertex_index;
  assign out_ch.is_new = res_r.is_new;
  assign out_ch.table_full = res_r.table_full;
  assign cfg_pready = 1'b1;

  // register read back
  always_comb begin
    unique case (cfg_paddr)
      vwd_pkg::RegPosTol: cfg_prdata = {16'd0, cfg_r.pos_tol};
      vwd_pkg::RegTexTol: cfg_prdata = {16'd0, cfg_r.tex_tol};
      vwd_pkg::RegCosThr: cfg_prdata = {17'd0, cfg_r.cos_thr};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  vwd_table u_table (
    .clk(clk), .we(we), .waddr(count_r[IdxW-1:0]), .wvtx(cur_r), .wcolor(color_r),
    .raddr(rd_r[IdxW-1:0]), .rvtx(ent)
  );

  vwd_match u_match (.clk(clk), .cfg(cfg_r), .cur(cur_r), .ent(ent), .hit(hit));

  assign chk_r = k2_r;

  // sequencer: issue reads, watch compare results, finish
  always_comb begin
    state_nxt = state_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    res_nxt   = res_r;
    we        = 1'b0;
    unique case (state_r)
      StIdle: begin
        if (in_acc) begin
          state_nxt = StScan;
          rd_nxt    = '0;
          if (in_ch.first_of_surface) begin
            count_nxt = '0;
          end
        end
      end
      StScan: begin
        if (vld_r[1] && hit) begin
          res_nxt   = '{vertex_index: vwd_pkg::OutIdxW'(chk_r), is_new: 1'b0,
                        table_full: 1'b0};
          state_nxt = StOut;
        end else if (rd_r >= count_r && vld_r == 2'd0) begin
          state_nxt = StDone;
        end else if (rd_r < count_r) begin
          rd_nxt = rd_r + 1'b1;
        end
      end
      StDone: begin
        if (count_r >= CntW'(vwd_pkg::MaxVerts)) begin
          res_nxt = '{vertex_index: '0, is_new: 1'b0, table_full: 1'b1};
        end else begin
          we        = 1'b1;
          res_nxt   = '{vertex_index: vwd_pkg::OutIdxW'(count_r), is_new: 1'b1,
                        table_full: 1'b0};
          count_nxt = count_r + 1'b1;
        end
        state_nxt = StOut;
      end
      StOut: begin
        if (out_ch.ready) begin
          state_nxt = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      count_r <= '0;
      rd_r    <= '0;
      vld_r   <= '0;
      cfg_r   <= '{pos_tol: 16'd41, tex_tol: 16'd66, cos_thr: 15'd16368};
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rd_r    <= rd_nxt;
      vld_r   <= (state_r == StScan) ?
                 {vld_r[0], (rd_r < count_r) && !(vld_r[1] && hit)} : 2'd0;
      if (cfg_wr) begin
        unique case (cfg_paddr)
          vwd_pkg::RegPosTol: cfg_r.pos_tol <= cfg_pwdata[15:0];
          vwd_pkg::RegTexTol: cfg_r.tex_tol <= cfg_pwdata[15:0];
          vwd_pkg::RegCosThr: cfg_r.cos_thr <= cfg_pwdata[14:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    k1_r  <= rd_r;
    k2_r  <= k1_r;
    if (in_acc) begin
      cur_r   <= '{pos_x: in_ch.pos_x, pos_y: in_ch.pos_y, pos_z: in_ch.pos_z,
                   tex_s: in_ch.tex_s, tex_t: in_ch.tex_t, normal_x: in_ch.normal_x,
                   normal_y: in_ch.normal_y, normal_z: in_ch.normal_z};
      color_r <= in_ch.color_rgba;
    end
  end
endmodule

>>> src/vwd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module vwd_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/vwd_match.sv
// Shared compare unit: two pipelined stages test one stored entry against the request.
`timescale 1ns / 1ps
module vwd_match (
  input  logic           clk,
  input  vwd_pkg::cfg_t  cfg,
  input  vwd_pkg::vtx_t  cur,
  input  vwd_pkg::vtx_t  ent,
  output logic           hit
);
  logic               geo_ok_r;
  logic               zero_ok_r;
  logic signed [32:0] dot_nxt;
  logic               dot_ge;
  logic signed [31:0] nx_r;
  logic signed [31:0] ny_r;
  logic signed [31:0] nz_r;

  function automatic logic near(input logic signed [31:0] a, input logic signed [31:0] b,
                                input logic [15:0] tol);
    logic signed [32:0] d;
    logic [32:0] m;
    begin
      d = 33'(a) - 33'(b);
      m = d[32] ? 33'(-d) : 33'(d);
      near = m <= {17'd0, tol};
    end
  endfunction

  // stage one: tolerance tests, the zero-normal test and the three normal products
  always_ff @(posedge clk) begin
    geo_ok_r  <= near(ent.pos_x, cur.pos_x, cfg.pos_tol) &&
                 near(ent.pos_y, cur.pos_y, cfg.pos_tol) &&
                 near(ent.pos_z, cur.pos_z, cfg.pos_tol) &&
                 near(ent.tex_s, cur.tex_s, cfg.tex_tol) &&
                 near(ent.tex_t, cur.tex_t, cfg.tex_tol);
    zero_ok_r <= (ent.normal_x == 16'sd0) && (ent.normal_y == 16'sd0) &&
                 (ent.normal_z == 16'sd0) && (cur.normal_x == 16'sd0) &&
                 (cur.normal_y == 16'sd0) && (cur.normal_z == 16'sd0);
    nx_r <= ent.normal_x * cur.normal_x;
    ny_r <= ent.normal_y * cur.normal_y;
    nz_r <= ent.normal_z * cur.normal_z;
  end

  // stage two: sum products and compare against the scaled threshold
  assign dot_nxt = 33'(nx_r) + 33'(ny_r) + 33'(nz_r);
  assign dot_ge  = dot_nxt >= $signed({4'd0, cfg.cos_thr, 14'd0});
  assign hit     = geo_ok_r && (zero_ok_r || dot_ge);
endmodule

>>> src/vwd_table.sv
// Vertex table: one RAM per entry field group, one read and one write per cycle.
`timescale 1ns / 1ps
module vwd_table (
  input  logic                      clk,
  input  logic                      we,
  input  logic [vwd_pkg::IdxW-1:0]  waddr,
  input  vwd_pkg::vtx_t             wvtx,
  input  logic [31:0]               wcolor,
  input  logic [vwd_pkg::IdxW-1:0]  raddr,
  output vwd_pkg::vtx_t             rvtx
);
  logic [31:0] rcolor;

  vwd_ram #(.Width(vwd_pkg::EntryW), .Depth(vwd_pkg::MaxVerts)) u_geo (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wvtx), .raddr(raddr), .rdata(rvtx)
  );

  // color is only stored; its read port is idle
  vwd_ram #(.Width(32), .Depth(vwd_pkg::MaxVerts)) u_color (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wcolor), .raddr(raddr), .rdata(rcolor)
  );

  logic unused_c;
  assign unused_c = ^rcolor;
endmodule

>>> src/vwd_checker.sv
// Port-level checker for the vertex weld block, bound to the top level.
`timescale 1ns / 1ps
`include "vertex_weld_dedup_defines.svh"
module vwd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_new,
  input logic       out_table_full
);
  `VWD_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready, "ready while result held")
  `VWD_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid, !(out_is_new && out_table_full), "both flags")
  `VWD_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready, "ready after request")
  `VWD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind vertex_weld_dedup vwd_checker u_vwd_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_is_new(out_ch.is_new),
  .out_table_full(out_ch.table_full)
);
